// ----- sv/abd_pkg.sv -----
// abd_pkg: shared types, constants and field arithmetic for the AES block decrypt unit.
// Depends on nothing; imported by abd_round and aes_block_decrypt_unit.
package abd_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int NUM_BYTES  = 16;
  localparam int BLOCK_W    = 8 * NUM_BYTES;
  localparam int KEY_DEPTH  = MAX_ROUNDS + 1;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int TBL_DEPTH  = 256;
  localparam int RC_W       = 4;
  localparam logic [RC_W-1:0] RC_RESET = 4'd10;

  // request function codes
  localparam logic [1:0] FUNC_TABLE   = 2'd0;
  localparam logic [1:0] FUNC_KEY     = 2'd1;
  localparam logic [1:0] FUNC_DECRYPT = 2'd2;

  // GF(2^8) reduction
  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] GF_MSB  = 8'h80;

  // inverse row shift: output byte i takes state byte UNSHIFT_SRC[i]
  localparam logic [3:0] UNSHIFT_SRC [NUM_BYTES] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_KEY   = 2'd2,
    OP_ROUND = 2'd3
  } round_op_t;

  typedef struct packed {
    round_op_t op;
    logic      last;
  } round_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    logic [7:0] sh;
    sh = {b[6:0], 1'b0};
    if ((b & GF_MSB) != 8'h00) sh = sh ^ GF_POLY;
    return sh;
  endfunction

  // inverse MixColumns on one 4-byte column, byte 0 in the top bits
  function automatic logic [31:0] unmix_col(input logic [31:0] col);
    logic [7:0] a   [4];
    logic [7:0] m9  [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i]   = col[31-8*i -: 8];
      x2     = xtime(a[i]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[i]  = x8 ^ a[i];
      m11[i] = x8 ^ x2 ^ a[i];
      m13[i] = x8 ^ x4 ^ a[i];
      m14[i] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
  endfunction

endpackage

// ----- sv/aes_block_decrypt_unit.sv -----
// aes_block_decrypt_unit: top level of the AES inverse cipher block.
// Uses abd_pkg, abd_ram (table copies and key store) and abd_round.
//
// Input channel (in_valid / in_stall), one request per accepted edge:
//   table write puts in_table_entry at inverse S-box entry in_index; key write
//   stores {in_block_high, in_block_low} as round key in_index (0..14, larger
//   ones dropped); decrypt gives one result; other codes are dropped.
//   Load the table and keys 0..round_count before decrypting.
// Sequence, N = effective round count (1..14): table and key writes leave the
//   unit idle. A decrypt loads the block in the accept cycle, then runs key
//   fetch, initial key add, N rounds (16 table copies read, then key add and
//   inverse mix, no mix in the last) and a handoff. in_stall is high while busy.
// Output channel (out_valid / out_stall): the result waits in an output
//   register while the unit takes the next request; a finished block holds
//   in the handoff state while the register is full and out_stall is high.
// Config (cfg_valid / cfg_ready): cfg_round_count, always ready; write only
//   while idle (not enforced). Zero acts as 1, values above 14 act as 14.
// Reset (rst_n, synchronous): round count 10, no result pending, idle.
//   Table and key contents are not cleared.
module aes_block_decrypt_unit import abd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  // request channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_index,
  input  logic [7:0]      in_table_entry,
  input  logic [63:0]     in_block_high,
  input  logic [63:0]     in_block_low,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     out_plain_high,
  output logic [63:0]     out_plain_low,
  // config channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [RC_W-1:0] cfg_round_count
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_KEY  = 6'b000010,  // key fetch for the initial add
    S_ADD  = 6'b000100,  // initial key add
    S_SUB  = 6'b001000,  // table and key reads in flight
    S_MIX  = 6'b010000,  // key add and inverse mix
    S_DONE = 6'b100000   // wait for output register
  } state_t;

  state_t state_r, state_nxt;

  logic [RC_W-1:0]   round_count_r;
  logic [KEY_AW-1:0] round_r, round_nxt;
  logic [KEY_AW-1:0] rounds_eff;

  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_hi_r, out_lo_r;
  logic              out_load;

  logic              in_accept;
  logic              tbl_we;
  logic              key_we;

  round_ctl_t         rctl;
  logic [BLOCK_W-1:0] tbl_addr;
  logic [BLOCK_W-1:0] tbl_q;
  logic [BLOCK_W-1:0] key_q;
  logic [BLOCK_W-1:0] cipher_state;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= RC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      round_count_r <= cfg_round_count;
    end
  end

  // clamp to 1..MAX_ROUNDS
  always_comb begin
    if (round_count_r == '0) begin
      rounds_eff = KEY_AW'(1);
    end else if (int'(round_count_r) > MAX_ROUNDS) begin
      rounds_eff = KEY_AW'(MAX_ROUNDS);
    end else begin
      rounds_eff = KEY_AW'(round_count_r);
    end
  end

  // --------------------------------------------------------- request intake
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign tbl_we    = in_accept && (in_func == FUNC_TABLE);
  assign key_we    = in_accept && (in_func == FUNC_KEY) && (int'(in_index) <= MAX_ROUNDS);

  // ------------------------------------------------------------ storage
  // One table copy per state byte so a whole round is looked up at once.
  for (genvar j = 0; j < NUM_BYTES; j++) begin : g_tbl
    abd_ram #(
      .WIDTH (8),
      .DEPTH (TBL_DEPTH)
    ) u_tbl (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (in_index),
      .wdata (in_table_entry),
      .raddr (tbl_addr[BLOCK_W-1-8*j -: 8]),
      .rdata (tbl_q[BLOCK_W-1-8*j -: 8])
    );
  end

  // Key store, one full 128-bit key per row, read at the current round.
  abd_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (KEY_DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_index[KEY_AW-1:0]),
    .wdata ({in_block_high, in_block_low}),
    .raddr (round_r),
    .rdata (key_q)
  );

  // ------------------------------------------------------------ datapath
  abd_round u_round (
    .clk      (clk),
    .ctl      (rctl),
    .blk_in   ({in_block_high, in_block_low}),
    .tbl_q    (tbl_q),
    .key_q    (key_q),
    .tbl_addr (tbl_addr),
    .state    (cipher_state)
  );

  // ------------------------------------------------------------ sequencer
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    rctl.op   = OP_HOLD;
    rctl.last = (round_r == '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_func == FUNC_DECRYPT)) begin
          rctl.op   = OP_LOAD;
          round_nxt = rounds_eff;
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        rctl.op   = OP_KEY;
        round_nxt = round_r - KEY_AW'(1);
        state_nxt = S_SUB;
      end
      S_SUB: begin
        state_nxt = S_MIX;
      end
      S_MIX: begin
        rctl.op = OP_ROUND;
        if (round_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          round_nxt = round_r - KEY_AW'(1);
          state_nxt = S_SUB;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  // ------------------------------------------------------------ output reg
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hi_r <= cipher_state[BLOCK_W-1 -: 64];
      out_lo_r <= cipher_state[63:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plain_high = out_hi_r;
  assign out_plain_low  = out_lo_r;

endmodule

// ----- sv/abd_ram.sv -----
// abd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module abd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/abd_round.sv -----
// abd_round: shared round datapath holding the 128-bit cipher state.
// Generates the table lookup addresses and applies key add / inverse mix. Uses abd_pkg.
module abd_round import abd_pkg::*; (
  input  logic               clk,
  input  round_ctl_t         ctl,
  input  logic [BLOCK_W-1:0] blk_in,
  input  logic [BLOCK_W-1:0] tbl_q,
  input  logic [BLOCK_W-1:0] key_q,
  output logic [BLOCK_W-1:0] tbl_addr,
  output logic [BLOCK_W-1:0] state
);

  logic [BLOCK_W-1:0] state_r;
  logic [BLOCK_W-1:0] state_nxt;
  logic [BLOCK_W-1:0] subbed;
  logic [BLOCK_W-1:0] unmixed;

  // lookup addresses carry the inverse row shift
  always_comb begin
    for (int j = 0; j < NUM_BYTES; j++) begin
      tbl_addr[BLOCK_W-1-8*j -: 8] = state_r[BLOCK_W-1-8*int'(UNSHIFT_SRC[j]) -: 8];
    end
  end

  assign subbed = tbl_q ^ key_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      unmixed[BLOCK_W-1-32*c -: 32] = unmix_col(subbed[BLOCK_W-1-32*c -: 32]);
    end
  end

  always_comb begin
    case (ctl.op)
      OP_LOAD:  state_nxt = blk_in;
      OP_KEY:   state_nxt = state_r ^ key_q;
      OP_ROUND: state_nxt = ctl.last ? subbed : unmixed;
      default:  state_nxt = state_r;
    endcase
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign state = state_r;

endmodule
